// ===== sv/denu_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package denu_pkg;

  typedef enum logic [0:0] {
    REG_DAMP_FACTOR = 1'b0,
    REG_TIME_STEP   = 1'b1
  } cfg_reg_t;

  localparam int QW = 33;  // quotient bits kept; anything larger clamps

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_SATURATED = 2'd1,
    ST_ZERO_MASS = 2'd2
  } status_t;

  // One item as it travels down the pipeline; each stage fills its own fields.
  typedef struct packed {
    logic signed [31:0] fe;
    logic signed [31:0] fi;
    logic        [30:0] mass;
    logic signed [31:0] v_old;
    logic signed [31:0] u_old;
    logic               a_fix;
    logic signed [31:0] a_pre;
    logic               v_fix;
    logic signed [31:0] v_pre;
    logic signed [32:0] net;
    logic        [32:0] nmag;
    logic        [33:0] damp;
    logic               neg;
    logic        [34:0] mag;
    logic        [QW-1:0] dlow;
    logic        [30:0] rem;
    logic        [QW-1:0] q;
    logic               ovf;
    logic               zmass;
    logic               sat_a;
    logic signed [31:0] accel;
    logic        [31:0] prod;
    logic               sat_v;
    logic signed [31:0] vel;
    logic signed [31:0] inc;
    logic signed [31:0] disp;
    status_t            status;
  } item_t;

endpackage
`default_nettype wire

// ===== sv/denu_in_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
interface denu_in_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] force_external;
  logic signed [31:0] force_internal;
  logic        [30:0] node_mass;
  logic signed [31:0] velocity_old;
  logic signed [31:0] displacement_old;
  logic               accel_fixed;
  logic signed [31:0] accel_prescribed;
  logic               vel_fixed;
  logic signed [31:0] vel_prescribed;

  modport source (
    output valid, force_external, force_internal, node_mass, velocity_old,
           displacement_old, accel_fixed, accel_prescribed, vel_fixed, vel_prescribed,
    input  ready
  );
  modport sink (
    input  valid, force_external, force_internal, node_mass, velocity_old,
           displacement_old, accel_fixed, accel_prescribed, vel_fixed, vel_prescribed,
    output ready
  );
endinterface

interface denu_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] accel_new;
  logic signed [31:0] velocity_new;
  logic signed [31:0] disp_increment;
  logic signed [31:0] displacement_new;
  logic        [1:0]  status;

  modport source (
    output valid, accel_new, velocity_new, disp_increment, displacement_new, status,
    input  ready
  );
  modport sink (
    input  valid, accel_new, velocity_new, disp_increment, displacement_new, status,
    output ready
  );
endinterface
`default_nettype wire

// ===== sv/denu_div_step.sv =====
`timescale 1ns / 1ps
`default_nettype none
// One restoring division step: bring down one dividend bit, compare, subtract.
module denu_div_step (
  input  wire logic [30:0]             rem,
  input  wire logic                    dbit,
  input  wire logic [30:0]             mass,
  input  wire logic [denu_pkg::QW-1:0] q,
  output logic      [30:0]             rem_next,
  output logic      [denu_pkg::QW-1:0] q_next
);
  logic [31:0] r2;
  logic [31:0] diff;
  logic        ge;

  always_comb begin
    r2       = {rem, dbit};
    diff     = r2 - {1'b0, mass};
    ge       = (r2 >= {1'b0, mass});
    rem_next = ge ? diff[30:0] : r2[30:0];
    q_next   = {q[denu_pkg::QW-2:0], ge};
  end
endmodule
`default_nettype wire

// ===== sv/damped_explicit_node_update.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Throughput: one item per cycle when not stalled by item_out.ready; the 33-stage
// restoring divider takes one quotient bit per stage, stages advance independently,
// and bubbles are squeezed out. Reset (rst, synchronous) empties the pipeline and
// clears damp_factor and time_step to zero.
module damped_explicit_node_update #(
  parameter int FRAC_BITS = 16
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_we,
  input  wire logic [0:0]  cfg_index,
  input  wire logic [31:0] cfg_data,
  denu_in_if.sink          item_in,
  denu_out_if.source       item_out
);
  localparam int QW     = denu_pkg::QW;
  localparam int DW     = 35 + FRAC_BITS;
  localparam int HW     = DW - QW;
  localparam int S_DIV0 = 5;
  localparam int S_ACC  = S_DIV0 + QW;
  localparam int NS     = S_ACC + 5;

  logic [16:0] damp_factor;
  logic [31:0] time_step;

  always_ff @(posedge clk) begin
    if (rst) begin
      damp_factor <= '0;
      time_step   <= '0;
    end else if (cfg_we) begin
      unique case (denu_pkg::cfg_reg_t'(cfg_index))
        denu_pkg::REG_DAMP_FACTOR: damp_factor <= cfg_data[16:0];
        denu_pkg::REG_TIME_STEP:   time_step   <= cfg_data;
        default: ;
      endcase
    end
  end

  denu_pkg::item_t pipe     [NS];
  denu_pkg::item_t pipe_next[NS];
  logic [NS-1:0]   v;
  logic [NS:0]     en;

  assign en[NS] = item_out.ready;
  assign item_in.ready = en[0];

  genvar i;
  generate
    for (i = 0; i < NS; i++) begin : g_stage
      assign en[i] = !v[i] || en[i+1];

      always_ff @(posedge clk) begin
        if (rst) begin
          v[i] <= 1'b0;
        end else if (en[i]) begin
          if (i == 0) v[i] <= item_in.valid;
          else        v[i] <= v[(i == 0) ? 0 : i-1];
        end
      end

      always_ff @(posedge clk) begin
        if (en[i]) pipe[i] <= pipe_next[i];
      end

      if (i == 0) begin : g_cap
        always_comb begin
          pipe_next[i]       = '0;
          pipe_next[i].fe    = item_in.force_external;
          pipe_next[i].fi    = item_in.force_internal;
          pipe_next[i].mass  = item_in.node_mass;
          pipe_next[i].v_old = item_in.velocity_old;
          pipe_next[i].u_old = item_in.displacement_old;
          pipe_next[i].a_fix = item_in.accel_fixed;
          pipe_next[i].a_pre = item_in.accel_prescribed;
          pipe_next[i].v_fix = item_in.vel_fixed;
          pipe_next[i].v_pre = item_in.vel_prescribed;
        end
      end else if (i == 1) begin : g_net
        logic signed [32:0] n;
        always_comb begin
          n = $signed({pipe[i-1].fe[31], pipe[i-1].fe})
            - $signed({pipe[i-1].fi[31], pipe[i-1].fi});
          pipe_next[i]      = pipe[i-1];
          pipe_next[i].net  = n;
          pipe_next[i].nmag = n[32] ? 33'(-n) : 33'(n);
        end
      end else if (i == 2) begin : g_damp
        logic [49:0] dprod;
        always_comb begin
          dprod = 50'(damp_factor) * 50'(pipe[i-1].nmag);
          pipe_next[i]      = pipe[i-1];
          pipe_next[i].damp = dprod[49:16];
        end
      end else if (i == 3) begin : g_sign
        logic signed [35:0] ne;
        logic signed [35:0] de;
        logic signed [35:0] n2;
        logic        [35:0] nm;
        always_comb begin
          ne = 36'(pipe[i-1].net);
          de = $signed({2'b00, pipe[i-1].damp});
          // damping opposes the velocity direction
          if (pipe[i-1].v_old > 0)      n2 = ne - de;
          else if (pipe[i-1].v_old < 0) n2 = ne + de;
          else                          n2 = ne;
          nm = n2[35] ? 36'(-n2) : 36'(n2);
          pipe_next[i]     = pipe[i-1];
          pipe_next[i].neg = n2[35];
          pipe_next[i].mag = nm[34:0];
        end
      end else if (i == 4) begin : g_divpre
        logic [DW-1:0] dvd;
        logic [HW-1:0] hi;
        always_comb begin
          dvd = {pipe[i-1].mag, {FRAC_BITS{1'b0}}};
          hi  = dvd[DW-1:QW];
          pipe_next[i]       = pipe[i-1];
          pipe_next[i].dlow  = dvd[QW-1:0];
          // quotient would need more than QW bits: clamp later
          pipe_next[i].ovf   = ({{(32-HW){1'b0}}, hi} >= {1'b0, pipe[i-1].mass});
          pipe_next[i].rem   = {{(31-HW){1'b0}}, hi};
          pipe_next[i].q     = '0;
          pipe_next[i].zmass = (pipe[i-1].mass == '0) && !pipe[i-1].a_fix;
        end
      end else if (i < S_ACC) begin : g_div
        logic [30:0]   r_n;
        logic [QW-1:0] q_n;
        denu_div_step u_step (
          .rem      (pipe[i-1].rem),
          .dbit     (pipe[i-1].dlow[S_ACC-1-i]),
          .mass     (pipe[i-1].mass),
          .q        (pipe[i-1].q),
          .rem_next (r_n),
          .q_next   (q_n)
        );
        always_comb begin
          pipe_next[i]     = pipe[i-1];
          pipe_next[i].rem = r_n;
          pipe_next[i].q   = q_n;
        end
      end else if (i == S_ACC) begin : g_accel
        logic [QW-1:0] qc;
        always_comb begin
          pipe_next[i] = pipe[i-1];
          qc = (pipe[i-1].ovf || pipe[i-1].q > {1'b1, 32'd0}) ? {1'b1, 32'd0}
                                                              : pipe[i-1].q;
          pipe_next[i].sat_a = 1'b0;
          if (pipe[i-1].a_fix) begin
            pipe_next[i].accel = pipe[i-1].a_pre;
          end else if (pipe[i-1].zmass) begin
            pipe_next[i].accel = '0;
          end else if (pipe[i-1].neg) begin
            if (qc > {1'b0, 32'h8000_0000}) begin
              pipe_next[i].accel = 32'sh8000_0000;
              pipe_next[i].sat_a = 1'b1;
            end else begin
              pipe_next[i].accel = $signed(32'(-qc));
            end
          end else begin
            if (qc >= {1'b0, 32'h8000_0000}) begin
              pipe_next[i].accel = 32'sh7FFF_FFFF;
              pipe_next[i].sat_a = 1'b1;
            end else begin
              pipe_next[i].accel = $signed(qc[31:0]);
            end
          end
        end
      end else if (i == S_ACC + 1 || i == S_ACC + 3) begin : g_mul
        logic [31:0] val;
        logic [31:0] vmag;
        logic [63:0] p;
        always_comb begin
          val  = (i == S_ACC + 1) ? pipe[i-1].accel : pipe[i-1].vel;
          vmag = val[31] ? 32'(-val) : val;
          p    = 64'(vmag) * 64'(time_step);
          pipe_next[i]      = pipe[i-1];
          pipe_next[i].prod = p[63:32];
        end
      end else if (i == S_ACC + 2) begin : g_vel
        logic signed [32:0] s;
        always_comb begin
          pipe_next[i] = pipe[i-1];
          if (pipe[i-1].accel[31]) s = 33'(pipe[i-1].v_old) - $signed({1'b0, pipe[i-1].prod});
          else                     s = 33'(pipe[i-1].v_old) + $signed({1'b0, pipe[i-1].prod});
          pipe_next[i].sat_v = 1'b0;
          if (pipe[i-1].v_fix) begin
            pipe_next[i].vel   = pipe[i-1].v_pre;
            pipe_next[i].accel = '0;
            pipe_next[i].sat_a = 1'b0;
          end else if (s > 33'sh0_7FFF_FFFF) begin
            pipe_next[i].vel   = 32'sh7FFF_FFFF;
            pipe_next[i].sat_v = 1'b1;
          end else if (s < -33'sh0_8000_0000) begin
            pipe_next[i].vel   = 32'sh8000_0000;
            pipe_next[i].sat_v = 1'b1;
          end else begin
            pipe_next[i].vel   = s[31:0];
          end
        end
      end else begin : g_disp
        logic signed [31:0] inc;
        logic signed [32:0] s;
        logic               sat_u;
        always_comb begin
          pipe_next[i] = pipe[i-1];
          inc = pipe[i-1].vel[31] ? $signed(32'(-pipe[i-1].prod)) : $signed(pipe[i-1].prod);
          s   = 33'(pipe[i-1].u_old) + 33'(inc);
          sat_u = 1'b0;
          pipe_next[i].inc = inc;
          if (s > 33'sh0_7FFF_FFFF) begin
            pipe_next[i].disp = 32'sh7FFF_FFFF;
            sat_u = 1'b1;
          end else if (s < -33'sh0_8000_0000) begin
            pipe_next[i].disp = 32'sh8000_0000;
            sat_u = 1'b1;
          end else begin
            pipe_next[i].disp = s[31:0];
          end
          priority if (pipe[i-1].zmass)
            pipe_next[i].status = denu_pkg::ST_ZERO_MASS;
          else if (pipe[i-1].sat_a || pipe[i-1].sat_v || sat_u)
            pipe_next[i].status = denu_pkg::ST_SATURATED;
          else
            pipe_next[i].status = denu_pkg::ST_OK;
        end
      end
    end
  endgenerate

  assign item_out.valid            = v[NS-1];
  assign item_out.accel_new        = pipe[NS-1].accel;
  assign item_out.velocity_new     = pipe[NS-1].vel;
  assign item_out.disp_increment   = pipe[NS-1].inc;
  assign item_out.displacement_new = pipe[NS-1].disp;
  assign item_out.status           = pipe[NS-1].status;

  a_status_code: assert property (@(posedge clk) disable iff (rst)
    item_out.valid |-> item_out.status <= denu_pkg::ST_ZERO_MASS)
    else $error("undefined status code");

  a_zero_mass_accel: assert property (@(posedge clk) disable iff (rst)
    item_out.valid && item_out.status == denu_pkg::ST_ZERO_MASS |-> item_out.accel_new == 0)
    else $error("zero mass item with nonzero acceleration");

  a_stall_source: assert property (@(posedge clk) disable iff (rst)
    !item_in.ready |-> item_out.valid && !item_out.ready)
    else $error("input held off without an output stall");
endmodule
`default_nettype wire
